// File: rtl/bounded_double_ended_queue_core_defines.svh
// Assertion macros shared by the checker files of the bounded deque core.
// Each macro expects clk and arst_n in scope of the module that uses it.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bdq_pkg.sv
// Shared types and constants of the bounded deque core.
// No dependencies; every other file but bdq_mem and the defines header imports it.
package bdq_pkg;

	localparam int VAL_W   = 32;
	localparam int HELD_W  = 6;
	localparam int CNT_W   = 6;
	localparam int TDATA_W = 40;
	localparam int TUSER_W = 3;

	typedef enum logic [2:0] {
		FN_PUSH_BACK  = 3'd0,
		FN_PUSH_FRONT = 3'd1,
		FN_POP_BACK   = 3'd2,
		FN_POP_FRONT  = 3'd3,
		FN_PEEK_FRONT = 3'd4,
		FN_PEEK_BACK  = 3'd5,
		FN_DROP       = 3'd6,
		FN_DRAIN      = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		SQ_IDLE,
		SQ_RUN
	} seq_state_t;

	typedef struct packed {
		status_t             status;
		logic                has_value;
		logic [HELD_W-1:0]   held;
		logic                last;
	} res_meta_t;

endpackage

// File: rtl/bdq_mem.sv
// Slot store of the bounded deque: one write port, one registered read port.
// Depends on nothing.
module bdq_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: rtl/bdq_obuf.sv
// Two-entry result buffer between the deque pipeline and the output stream.
// Depends on bdq_pkg.
module bdq_obuf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr,
	input  bdq_pkg::res_meta_t          wr_meta,
	input  logic [bdq_pkg::VAL_W-1:0]   wr_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output bdq_pkg::res_meta_t          out_meta,
	output logic [bdq_pkg::VAL_W-1:0]   out_value,
	output logic [1:0]                  occ
);
	import bdq_pkg::*;

	res_meta_t         meta_q [2];
	logic [VAL_W-1:0]  value_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        occ_q;
	logic              pop;

	assign out_valid = (occ_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_meta  = meta_q[rd_ptr_q];
	assign out_value = value_q[rd_ptr_q];
	assign occ       = occ_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			meta_q[wr_ptr_q]  <= wr_meta;
			value_q[wr_ptr_q] <= wr_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			occ_q    <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			occ_q <= occ_q + {1'b0, wr} - {1'b0, pop};
		end
	end
endmodule

// File: rtl/bdq_seq.sv
// Request sequencer of the bounded deque: pointers, count, limit register and
// the drop/drain loop. Drives the slot store ports. Depends on bdq_pkg.
module bdq_seq #(
	parameter int DEPTH = 32,
	parameter int SW    = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  bdq_pkg::func_t              in_func,
	input  logic [bdq_pkg::VAL_W-1:0]   in_value,
	input  logic [bdq_pkg::CNT_W-1:0]   in_count,
	input  logic                        cfg_we,
	input  logic [bdq_pkg::CNT_W-1:0]   cfg_max,
	input  logic                        space_ok,
	output logic                        mem_we,
	output logic [$clog2(DEPTH)-1:0]    mem_waddr,
	output logic [SW-1:0]               mem_wdata,
	output logic                        mem_re,
	output logic [$clog2(DEPTH)-1:0]    mem_raddr,
	output logic                        res_valid,
	output bdq_pkg::res_meta_t          res_meta
);
	import bdq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = (CW > CNT_W) ? CW : CNT_W;
	localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);
	localparam logic [KW-1:0] DEPTH_K = KW'(DEPTH);

	seq_state_t        state_q, state_d;
	logic [AW-1:0]     front_q, front_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     rem_q, rem_d;
	logic [CNT_W-1:0]  max_q;

	logic [KW-1:0]     max_k, cap_k, cnt_k, want_k, clip_k, n_k;
	logic [CW-1:0]     n_c;
	logic              full, empty, accept, is_bulk, bulk_multi;
	logic [AW-1:0]     front_inc, front_dec, back_wr, back_rd;

	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
	                                          input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_A) begin
			sum = sum - DEPTH_A;
		end
		return sum[AW-1:0];
	endfunction

	assign max_k  = KW'(max_q);
	assign cap_k  = (max_q == '0 || max_k > DEPTH_K) ? DEPTH_K : max_k;
	assign cnt_k  = KW'(count_q);
	assign full   = (cnt_k >= cap_k);
	assign empty  = (count_q == '0);
	assign want_k = KW'(in_count);
	assign clip_k = (want_k > cnt_k) ? cnt_k : want_k;
	assign n_k    = (in_func == FN_DRAIN) ? cnt_k : clip_k;
	assign n_c    = CW'(n_k);

	assign front_inc = (front_q == LAST_IX) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? LAST_IX : front_q - 1'b1;
	assign back_wr   = slot_of(front_q, AW'(count_q));
	assign back_rd   = slot_of(front_q, AW'(count_q - 1'b1));

	assign in_ready   = (state_q == SQ_IDLE) && space_ok;
	assign accept     = in_valid && in_ready;
	assign is_bulk    = (in_func == FN_DROP) || (in_func == FN_DRAIN);
	assign bulk_multi = accept && is_bulk && !empty && (n_c > CW'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (bulk_multi) begin
					state_d = SQ_RUN;
				end
			end
			SQ_RUN: begin
				if (space_ok && rem_q == CW'(1)) begin
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	// datapath and outputs
	always_comb begin
		logic         ok;
		status_t      st;
		logic         hv;
		logic         fin;
		ok        = 1'b0;
		st        = ST_OK;
		hv        = 1'b0;
		fin       = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = back_wr;
		mem_wdata = in_value[SW-1:0];
		mem_re    = 1'b0;
		mem_raddr = front_q;
		front_d   = front_q;
		count_d   = count_q;
		rem_d     = rem_q;
		res_valid = 1'b0;
		case (state_q)
			SQ_IDLE: begin
				res_valid = accept;
				ok        = accept;
			end
			SQ_RUN: begin
				if (space_ok) begin
					res_valid = 1'b1;
					hv        = 1'b1;
					fin       = (rem_q == CW'(1));
					mem_re    = 1'b1;
					front_d   = front_inc;
					count_d   = count_q - 1'b1;
					rem_d     = rem_q - 1'b1;
				end
			end
			default: ;
		endcase
		if (ok) begin
			case (in_func)
				FN_PUSH_BACK, FN_PUSH_FRONT: begin
					if (full) begin
						st = ST_FULL;
					end else begin
						mem_we  = 1'b1;
						count_d = count_q + 1'b1;
						if (in_func == FN_PUSH_FRONT) begin
							mem_waddr = front_dec;
							front_d   = front_dec;
						end
					end
				end
				FN_POP_BACK, FN_POP_FRONT, FN_PEEK_FRONT, FN_PEEK_BACK: begin
					if (empty) begin
						st = ST_EMPTY;
					end else begin
						hv     = 1'b1;
						mem_re = 1'b1;
						if (in_func == FN_POP_BACK || in_func == FN_PEEK_BACK) begin
							mem_raddr = back_rd;
						end
						if (in_func == FN_POP_BACK) begin
							count_d = count_q - 1'b1;
						end
						if (in_func == FN_POP_FRONT) begin
							front_d = front_inc;
							count_d = count_q - 1'b1;
						end
					end
				end
				FN_DROP, FN_DRAIN: begin
					if (empty) begin
						st = ST_EMPTY;
					end else if (n_c != '0) begin
						// emit the oldest entry now, loop over the rest
						hv      = 1'b1;
						fin     = (n_c == CW'(1));
						mem_re  = 1'b1;
						front_d = front_inc;
						count_d = count_q - 1'b1;
						rem_d   = n_c - 1'b1;
					end
				end
				default: ;
			endcase
		end
		res_meta.status    = st;
		res_meta.has_value = hv;
		res_meta.held      = HELD_W'(count_d);
		res_meta.last      = fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			front_q <= '0;
			count_q <= '0;
			rem_q   <= '0;
			max_q   <= '0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (cfg_we) begin
				max_q <= cfg_max;
			end
		end
	end
endmodule

// File: rtl/bounded_double_ended_queue_core.sv
// Bounded deque core: stream in, stream out, one limit register.
// Depends on bdq_pkg, bdq_mem, bdq_seq and bdq_obuf.
//
// Requests enter on s_* (s_tuser = operation, s_tdata = push_value, drop_count).
// Results leave on m_* (m_tuser = status, has_value; m_tdata = out_value, held;
// m_tlast marks the final result of a request). cfg_* writes max_entries and
// is always ready; write it only while no request is in flight.
// A result reaches m_* through the slot store's registered read, beside the
// registered request metadata, and then through the result buffer.
// Push, pop and peek take one request per cycle while the result buffer has room;
// a drop or drain of more than one entry holds s_tready low and emits one result
// per cycle, again while the buffer has room, until its last entry is removed.
// A two-entry result buffer with credit tracking lets a new request be taken
// while a result waits; when m_tready stays low the buffer fills and s_tready
// drops, and everything holds until the receiver takes a beat.
// Reset clears the pointers, the count and the limit at once; no sweep of the
// slot store is needed, since no slot is read before it is written.
module bounded_double_ended_queue_core #(
	parameter int DEPTH      = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bdq_pkg::TDATA_W-1:0]   s_tdata,   // push_value[31:0], drop_count[37:32]
	input  logic [bdq_pkg::TUSER_W-1:0]   s_tuser,   // func[2:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bdq_pkg::TDATA_W-1:0]   m_tdata,   // out_value[31:0], held[37:32]
	output logic [bdq_pkg::TUSER_W-1:0]   m_tuser,   // status[1:0], has_value[2]
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bdq_pkg::CNT_W-1:0]     cfg_data
);
	import bdq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int SW = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;

	logic              space_ok, out_fire;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [SW-1:0]     mem_wdata, mem_rdata;
	logic              res_valid;
	res_meta_t         res_meta;
	logic              valid_s1;
	res_meta_t         meta_s1;
	logic [VAL_W-1:0]  value_s1;
	logic [1:0]        occ, credit;
	res_meta_t         out_meta;
	logic [VAL_W-1:0]  out_value;

	assign cfg_ready = 1'b1;
	assign out_fire  = m_tvalid && m_tready;
	// buffered plus in-flight results; a beat leaving frees a slot this cycle
	assign credit    = occ + {1'b0, valid_s1};
	assign space_ok  = (credit < 2'd2) || out_fire;

	bdq_seq #(
		.DEPTH (DEPTH),
		.SW    (SW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (func_t'(s_tuser[2:0])),
		.in_value  (s_tdata[31:0]),
		.in_count  (s_tdata[37:32]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_max   (cfg_data),
		.space_ok  (space_ok),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.res_valid (res_valid),
		.res_meta  (res_meta)
	);

	bdq_mem #(
		.DEPTH (DEPTH),
		.WIDTH (SW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1 <= res_meta;
	end

	assign value_s1 = meta_s1.has_value ? VAL_W'(mem_rdata) : '0;

	bdq_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (valid_s1),
		.wr_meta   (meta_s1),
		.wr_value  (value_s1),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_meta  (out_meta),
		.out_value (out_value),
		.occ       (occ)
	);

	assign m_tdata = {2'b00, out_meta.held, out_value};
	assign m_tuser = {out_meta.has_value, out_meta.status};
	assign m_tlast = out_meta.last;
endmodule

// File: rtl/bdq_checker.sv
// Port-level checks of the bounded deque core, bound to the top level.
// Depends on bdq_pkg and bounded_double_ended_queue_core_defines.svh.
`include "bounded_double_ended_queue_core_defines.svh"

module bdq_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [bdq_pkg::TDATA_W-1:0]   m_tdata,
	input  logic [bdq_pkg::TUSER_W-1:0]   m_tuser,
	input  logic                          m_tlast
);
	import bdq_pkg::*;

	// hold a stalled beat
	`BDQ_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

	// a returned entry only comes with ok status
	`BDQ_ASSERT_SAME(a_value_ok, m_tvalid && m_tuser[2], m_tuser[1:0] == ST_OK, "value on a non-ok result")

	// empty status means nothing held and a single, final result
	`BDQ_ASSERT_SAME(a_empty_held, m_tvalid && m_tuser[1:0] == ST_EMPTY, m_tdata[37:32] == '0 && m_tlast, "empty result with entries held")

	// a result without a value ends its request and carries a zero word
	`BDQ_ASSERT_SAME(a_novalue_last, m_tvalid && !m_tuser[2], m_tlast && m_tdata[31:0] == '0, "valueless result not final")
endmodule

bind bounded_double_ended_queue_core bdq_checker u_bdq_checker (.*);

// File: dv/bounded_double_ended_queue_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bounded_double_ended_queue_core: a directed sweep of every
// operation and corner case, then random requests, all checked against an in-bench deque mirror.
// Depends on bdq_pkg and the core RTL only.
module bounded_double_ended_queue_core_tb;
	import bdq_pkg::*;

	localparam int DEPTH       = 32;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 400;
	localparam int SETTLE      = 4;

	typedef struct {
		func_t       fn;
		logic [31:0] value;
		logic [5:0]  count;
	} request_t;

	typedef struct {
		status_t     status;
		logic        has_value;
		logic [31:0] value;
		logic [5:0]  held;
		logic        last;
	} result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata   = '0;
	logic [TUSER_W-1:0]   s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic [TUSER_W-1:0]   m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CNT_W-1:0]     cfg_data  = '0;
	logic                 hold_start = 1'b0;

	// deque mirror
	logic [31:0] mirror_slot [DEPTH];
	int          mirror_front = 0;
	int          mirror_count = 0;
	logic [5:0]  mirror_limit = '0;

	request_t req_q[$];
	result_t  result_q[$];
	request_t offered;

	int errors = 0;
	int accepted = 0;
	int beats = 0;
	int refused_pushes = 0;
	int empty_results = 0;
	int removed = 0;
	int gap_left = 0;
	int burst_left = 0;
	int hold_left = 0;
	int cycles = 0;
	int stall_mode = 0;
	int stall_left = 0;

	bounded_double_ended_queue_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void emit_result(status_t st, logic hv, logic [31:0] v, logic fin);
		result_t r;
		r.status    = st;
		r.has_value = hv;
		r.value     = v;
		r.held      = mirror_count[5:0];
		r.last      = fin;
		if (st == ST_EMPTY)
			empty_results++;
		result_q.push_back(r);
	endfunction

	function automatic logic [31:0] take_front();
		logic [31:0] v;
		v = mirror_slot[mirror_front];
		mirror_front = (mirror_front + 1) % DEPTH;
		mirror_count--;
		return v;
	endfunction

	// advance the mirror by one request and queue the beats it should produce
	function automatic void apply_request(request_t rq);
		int          cap;
		int          n;
		logic [31:0] v;
		cap = (mirror_limit == 0 || mirror_limit > DEPTH) ? DEPTH : int'(mirror_limit);
		case (rq.fn)
			FN_PUSH_BACK, FN_PUSH_FRONT: begin
				if (mirror_count >= cap) begin
					refused_pushes++;
					emit_result(ST_FULL, 1'b0, '0, 1'b1);
				end else begin
					if (rq.fn == FN_PUSH_BACK) begin
						mirror_slot[(mirror_front + mirror_count) % DEPTH] = rq.value;
					end else begin
						mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
						mirror_slot[mirror_front] = rq.value;
					end
					mirror_count++;
					emit_result(ST_OK, 1'b0, '0, 1'b1);
				end
			end
			FN_POP_BACK, FN_POP_FRONT, FN_PEEK_FRONT, FN_PEEK_BACK: begin
				if (mirror_count == 0) begin
					emit_result(ST_EMPTY, 1'b0, '0, 1'b1);
				end else begin
					case (rq.fn)
						FN_POP_BACK: begin
							v = mirror_slot[(mirror_front + mirror_count - 1) % DEPTH];
							mirror_count--;
						end
						FN_POP_FRONT: v = take_front();
						FN_PEEK_FRONT: v = mirror_slot[mirror_front];
						default: v = mirror_slot[(mirror_front + mirror_count - 1) % DEPTH];
					endcase
					emit_result(ST_OK, 1'b1, v, 1'b1);
				end
			end
			default: begin
				if (mirror_count == 0) begin
					emit_result(ST_EMPTY, 1'b0, '0, 1'b1);
				end else begin
					n = (rq.fn == FN_DRAIN) ? mirror_count : int'(rq.count);
					if (n > mirror_count)
						n = mirror_count;
					if (n == 0)
						emit_result(ST_OK, 1'b0, '0, 1'b1);
					for (int i = 0; i < n; i++) begin
						v = take_front();
						removed++;
						emit_result(ST_OK, 1'b1, v, i + 1 == n);
					end
				end
			end
		endcase
	endfunction

	// sender: bursts of back-to-back beats separated by random gaps
	always @(posedge clk) begin : tx_drive
		request_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_request(offered);
				accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (req_q.size() > 0) begin
					nxt = req_q.pop_front();
					offered = nxt;
					s_tvalid <= 1'b1;
					s_tuser <= nxt.fn;
					s_tdata <= {2'b00, nxt.count, nxt.value};
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, armed by a pulse on hold_start
	always @(posedge clk) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_start)
			hold_left <= LONG_HOLD;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// receiver: check each beat, then pick next ready from the current stall mode
	always @(posedge clk) begin : rx_check
		result_t     exp_r;
		logic        rdy;
		logic [31:0] got_value;
		logic [5:0]  got_held;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				beats++;
				got_value = m_tdata[31:0];
				got_held = m_tdata[37:32];
				if (result_q.size() == 0) begin
					errors++;
					$error("unexpected result beat: out_value %h held %0d", got_value, got_held);
				end else begin
					exp_r = result_q.pop_front();
					if (m_tuser[1:0] != exp_r.status) begin
						errors++;
						$error("status: expected %0d, got %0d", exp_r.status, m_tuser[1:0]);
					end
					if (m_tuser[2] != exp_r.has_value) begin
						errors++;
						$error("has_value: expected %0d, got %0d", exp_r.has_value, m_tuser[2]);
					end
					if (got_value != exp_r.value) begin
						errors++;
						$error("out_value: expected %h, got %h", exp_r.value, got_value);
					end
					if (got_held != exp_r.held) begin
						errors++;
						$error("held: expected %0d, got %0d", exp_r.held, got_held);
					end
					if (m_tlast != exp_r.last) begin
						errors++;
						$error("last: expected %0d, got %0d", exp_r.last, m_tlast);
					end
				end
			end
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(16, 96);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: rdy = 1'b1;
				1: rdy = $urandom_range(0, 3) != 0;
				2: rdy = $urandom_range(0, 1) != 0;
				default: rdy = $urandom_range(0, 9) == 0;
			endcase
			m_tready <= rdy && hold_left == 0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still expected", cycles, result_q.size());
			$display("bounded_double_ended_queue_core: mismatch");
			$finish;
		end
	end

	function automatic request_t make_request(int push_pct);
		request_t rq;
		int       r;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			rq.fn = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
		else if (r < push_pct + (100 - push_pct) * 88 / 100)
			rq.fn = func_t'($urandom_range(2, 5));
		else if ($urandom_range(0, 2) != 0)
			rq.fn = FN_DROP;
		else
			rq.fn = FN_DRAIN;
		case ($urandom_range(0, 9))
			0: rq.value = '0;
			1: rq.value = '1;
			default: rq.value = $urandom;
		endcase
		rq.count = $urandom_range(0, 3) != 0 ? 6'($urandom_range(0, 4))
			: 6'($urandom_range(0, 32));
		return rq;
	endfunction

	function automatic void add_req(func_t fn, logic [31:0] value, logic [5:0] count);
		request_t rq;
		rq.fn = fn;
		rq.value = value;
		rq.count = count;
		req_q.push_back(rq);
	endfunction

	task automatic wait_idle();
		while (req_q.size() != 0 || s_tvalid || result_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_limit(input logic [5:0] v);
		wait_idle();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		mirror_limit = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input logic [5:0] lim, input int n, input int push_pct,
			input bit long_hold);
		write_limit(lim);
		if (long_hold) begin
			hold_start <= 1'b1;
			@(posedge clk);
			hold_start <= 1'b0;
		end
		@(negedge clk);
		for (int i = 0; i < n; i++)
			req_q.push_back(make_request(push_pct));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// empty deque, every operation, then the boundary values and clipping
		write_limit(6'd0);
		@(negedge clk);
		add_req(FN_POP_BACK, '0, '0);
		add_req(FN_POP_FRONT, '0, '0);
		add_req(FN_PEEK_FRONT, '0, '0);
		add_req(FN_PEEK_BACK, '0, '0);
		add_req(FN_DROP, '0, 6'd5);
		add_req(FN_DRAIN, '0, '0);
		add_req(FN_PUSH_BACK, 32'h0000_0000, '0);
		add_req(FN_PUSH_FRONT, 32'hFFFF_FFFF, '0);
		add_req(FN_PUSH_BACK, 32'hA5A5_A5A5, 6'd63);
		add_req(FN_PUSH_FRONT, 32'h5A5A_5A5A, '0);
		add_req(FN_PEEK_FRONT, '0, '0);
		add_req(FN_PEEK_BACK, '0, '0);
		add_req(FN_DROP, '0, 6'd0);
		add_req(FN_POP_BACK, '0, '0);
		add_req(FN_POP_FRONT, '0, '0);
		add_req(FN_PUSH_BACK, 32'h1234_5678, '0);
		add_req(FN_DROP, '0, 6'd32);
		add_req(FN_PUSH_FRONT, 32'h0000_0001, '0);
		add_req(FN_PUSH_BACK, 32'h8000_0000, '0);
		add_req(FN_DRAIN, '0, '0);

		// single-entry limit: second push is refused
		write_limit(6'd1);
		@(negedge clk);
		add_req(FN_PUSH_BACK, 32'hDEAD_BEEF, '0);
		add_req(FN_PUSH_FRONT, 32'hCAFE_F00D, '0);
		add_req(FN_PEEK_BACK, '0, '0);
		add_req(FN_POP_FRONT, '0, '0);

		// fill to depth, then lower the limit under the count
		random_phase(6'd0, 80, 75, 1'b0);
		random_phase(6'd3, 60, 40, 1'b0);
		random_phase(6'd32, 70, 70, 1'b1);
		random_phase(6'd63, 70, 50, 1'b0);
		random_phase(6'd1, 40, 50, 1'b0);
		random_phase(6'($urandom_range(2, 31)), 70, 45, 1'b0);
		random_phase(6'd0, 40, 30, 1'b0);

		wait_idle();
		repeat (8) @(posedge clk);
		$display("run covered %0d requests and %0d result beats in %0d cycles", accepted, beats,
			cycles);
		$display("pushes refused when full: %0d, empty replies: %0d, entries dropped or drained: %0d",
			refused_pushes, empty_results, removed);
		if (errors == 0)
			$display("bounded_double_ended_queue_core: match");
		else
			$display("bounded_double_ended_queue_core: mismatch");
		$finish;
	end

endmodule
